### design/bfpa_pkg.sv
// Shared types and constants for the best-fit partition allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfpa_pkg;

  localparam int unsigned MAX_PARTS_DEF = 16;

  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IW  = 1;

  localparam logic [SIZE_W-1:0] TOTAL_RESET    = 8'd150;
  localparam logic [SIZE_W-1:0] RESERVED_RESET = 8'd20;

  localparam logic [CFG_IW-1:0] REG_TOTAL    = 1'b0;
  localparam logic [CFG_IW-1:0] REG_RESERVED = 1'b1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_LATE  = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              busy;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### design/best_fit_partition_allocator_core.sv
// Top level of the best-fit partition allocator.
`timescale 1ns / 1ps
`default_nettype none

// Best-fit fixed-partition allocator. Pulse start with in_op/in_size while busy
// is low. An add (in_op 0) inserts a partition into a size-sorted table; an
// allocation (in_op 1) takes the first free partition that holds the job. One
// result appears on the out_ ports for a single cycle with out_valid; it cannot
// be held off. A refused add, an add to an empty table or an allocation on an
// empty table is answered directly from IDLE. Any other sorted insert walks
// ADD_SCAN down over the k table entries larger than the new size, shifting
// each up, and passes through ADD_PUT when all are larger; an allocation walks
// ALLOC_SCAN up the sorted table to the chosen or last examined entry. The
// walks read the partition RAM one entry per cycle, and its read is registered.
// No clearing pass: the table is valid up to its fill count after reset.
module best_fit_partition_allocator_core #(
  parameter int unsigned MAX_PARTS = bfpa_pkg::MAX_PARTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_op,
  input  wire logic [bfpa_pkg::SIZE_W-1:0]    in_size,
  output logic                                out_valid,
  output logic      [bfpa_pkg::STAT_W-1:0]    out_status,
  output logic      [bfpa_pkg::INDEX_W-1:0]   out_part_index,
  output logic      [bfpa_pkg::ADDR_W-1:0]    out_start_addr,
  output logic      [bfpa_pkg::ADDR_W-1:0]    out_end_addr,
  output logic      [bfpa_pkg::SIZE_W-1:0]    out_waste,
  input  wire logic                           cfg_we,
  input  wire logic [bfpa_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [bfpa_pkg::CFG_W-1:0]     cfg_data
);

  import bfpa_pkg::*;

  localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);

  typedef enum logic [1:0] {
    IDLE,
    ADD_SCAN,
    ADD_PUT,
    ALLOC_SCAN
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] total_r, total_nxt;
  logic [SIZE_W-1:0] reserved_r, reserved_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [SIZE_W-1:0] used_r, used_nxt;
  logic              alloc_begun_r, alloc_begun_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [SIZE_W-1:0] job_r, job_nxt;
  logic [SIZE_W-1:0] sum_r, sum_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic [ADDR_W-1:0] start_addr_r, start_addr_nxt;
  logic [ADDR_W-1:0] end_addr_r, end_addr_nxt;
  logic [SIZE_W-1:0] waste_r, waste_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;

  logic [SIZE_W+1:0] space_diff;
  logic [SIZE_W-1:0] space_left;

  assign rd = entry_t'(ram_rdata);

  always_comb begin
    space_diff = {2'b00, total_r} - {2'b00, reserved_r} - {2'b00, used_r};
    space_left = space_diff[SIZE_W+1] ? '0 : space_diff[SIZE_W-1:0];
  end

  bfpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTS)
  ) u_part_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic          do_ins;
    logic [AW-1:0] ins_pos;
    logic [31:0]   idx_w;
    logic [ADDR_W-1:0] st_addr;

    do_ins  = 1'b0;
    ins_pos = '0;
    idx_w   = '0;
    st_addr = '0;

    state_nxt       = state_r;
    total_nxt       = total_r;
    reserved_nxt    = reserved_r;
    count_nxt       = count_r;
    used_nxt        = used_r;
    alloc_begun_nxt = alloc_begun_r;
    out_valid_nxt   = 1'b0;
    i_nxt           = i_r;
    pos_nxt         = pos_r;
    job_nxt         = job_r;
    sum_nxt         = sum_r;
    status_nxt      = status_r;
    index_nxt       = index_r;
    start_addr_nxt  = start_addr_r;
    end_addr_nxt    = end_addr_r;
    waste_nxt       = waste_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL:    total_nxt    = cfg_data[SIZE_W-1:0];
        REG_RESERVED: reserved_nxt = cfg_data[SIZE_W-1:0];
      endcase
    end

    unique case (state_r)
      IDLE: begin
        if (start) begin
          job_nxt = in_size;
          if (in_op == OP_ADD) begin
            if (alloc_begun_r) begin
              out_valid_nxt = 1'b1;
              status_nxt = ST_LATE;
              index_nxt = '0;
              start_addr_nxt = '0;
              end_addr_nxt = '0;
              waste_nxt = '0;
            end else if (count_r == CW'(MAX_PARTS) || in_size == '0 ||
                         in_size > space_left) begin
              out_valid_nxt = 1'b1;
              status_nxt = ST_FULL;
              index_nxt = '0;
              start_addr_nxt = '0;
              end_addr_nxt = '0;
              waste_nxt = '0;
            end else if (count_r == '0) begin
              do_ins  = 1'b1;
              ins_pos = '0;
              sum_nxt = '0;
            end else begin
              ram_raddr = AW'(count_r - CW'(1));
              i_nxt     = AW'(count_r - CW'(1));
              sum_nxt   = '0;
              state_nxt = ADD_SCAN;
            end
          end else begin
            alloc_begun_nxt = 1'b1;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt = ST_NOFIT;
              index_nxt = '0;
              start_addr_nxt = '0;
              end_addr_nxt = '0;
              waste_nxt = '0;
            end else begin
              ram_raddr = '0;
              i_nxt     = '0;
              sum_nxt   = '0;
              state_nxt = ALLOC_SCAN;
            end
          end
        end
      end

      ADD_SCAN: begin
        if (rd.size > job_r) begin
          ram_we    = 1'b1;
          ram_waddr = i_r + AW'(1);
          ram_wdata = rd;
          sum_nxt   = sum_r + rd.size;
          if (i_r == '0) begin
            pos_nxt   = '0;
            state_nxt = ADD_PUT;
          end else begin
            ram_raddr = i_r - AW'(1);
            i_nxt     = i_r - AW'(1);
          end
        end else begin
          do_ins  = 1'b1;
          ins_pos = i_r + AW'(1);
        end
      end

      ADD_PUT: begin
        do_ins  = 1'b1;
        ins_pos = pos_r;
      end

      ALLOC_SCAN: begin
        if (!rd.busy && rd.size >= job_r) begin
          ram_we         = 1'b1;
          ram_waddr      = i_r;
          ram_wdata.size = rd.size;
          ram_wdata.busy = 1'b1;
          idx_w          = 32'(i_r) + 32'd1;
          st_addr        = reserved_r + sum_r;
          out_valid_nxt  = 1'b1;
          status_nxt     = ST_OK;
          index_nxt      = idx_w[INDEX_W-1:0];
          start_addr_nxt = st_addr;
          end_addr_nxt   = st_addr + rd.size - ADDR_W'(1);
          waste_nxt      = rd.size - job_r;
          state_nxt      = IDLE;
        end else if (CW'(i_r) + CW'(1) == count_r) begin
          out_valid_nxt  = 1'b1;
          status_nxt     = ST_NOFIT;
          index_nxt      = '0;
          start_addr_nxt = '0;
          end_addr_nxt   = '0;
          waste_nxt      = '0;
          state_nxt      = IDLE;
        end else begin
          sum_nxt   = sum_r + rd.size;
          ram_raddr = i_r + AW'(1);
          i_nxt     = i_r + AW'(1);
        end
      end
    endcase

    // place the new partition; sum_nxt holds the sizes shifted above it
    if (do_ins) begin
      ram_we         = 1'b1;
      ram_waddr      = ins_pos;
      ram_wdata.size = job_nxt;
      ram_wdata.busy = 1'b0;
      count_nxt      = count_r + CW'(1);
      used_nxt       = used_r + job_nxt;
      idx_w          = 32'(ins_pos) + 32'd1;
      st_addr        = reserved_r + (used_r - sum_nxt);
      out_valid_nxt  = 1'b1;
      status_nxt     = ST_OK;
      index_nxt      = idx_w[INDEX_W-1:0];
      start_addr_nxt = st_addr;
      end_addr_nxt   = st_addr + job_nxt - ADDR_W'(1);
      waste_nxt      = '0;
      state_nxt      = IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= IDLE;
      total_r       <= TOTAL_RESET;
      reserved_r    <= RESERVED_RESET;
      count_r       <= '0;
      used_r        <= '0;
      alloc_begun_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      total_r       <= total_nxt;
      reserved_r    <= reserved_nxt;
      count_r       <= count_nxt;
      used_r        <= used_nxt;
      alloc_begun_r <= alloc_begun_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    pos_r        <= pos_nxt;
    job_r        <= job_nxt;
    sum_r        <= sum_nxt;
    status_r     <= status_nxt;
    index_r      <= index_nxt;
    start_addr_r <= start_addr_nxt;
    end_addr_r   <= end_addr_nxt;
    waste_r      <= waste_nxt;
  end

  assign busy           = (state_r != IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_part_index = index_r;
  assign out_start_addr = start_addr_r;
  assign out_end_addr   = end_addr_r;
  assign out_waste      = waste_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_PARTS))
    else $error("partition count beyond table depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  a_ok_has_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_part_index != '0 || MAX_PARTS > 30))
    else $error("successful transfer without partition index");

  a_no_add_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ADD_SCAN || state_r == ADD_PUT) |-> !alloc_begun_r)
    else $error("insert walk after allocation began");

  a_alloc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n)) |-> !$fell(alloc_begun_r))
    else $error("allocation flag dropped without reset");
`endif

endmodule

`default_nettype wire

### design/bfpa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bfpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the best-fit partition allocator core.
`timescale 1ns / 1ps

module tb;
  import bfpa_pkg::*;

  localparam int unsigned PARTS        = MAX_PARTS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = PARTS + 8;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] part_index;
    logic [ADDR_W-1:0]  start_addr;
    logic [ADDR_W-1:0]  end_addr;
    logic [SIZE_W-1:0]  waste;
  } answer_t;

  class partition_book;
    logic [SIZE_W-1:0] total_mem;
    logic [SIZE_W-1:0] reserved;
    logic [SIZE_W-1:0] space_left;
    logic [SIZE_W-1:0] sizes [PARTS];
    bit                taken [PARTS];
    int unsigned       count;
    bit                alloc_started;
    answer_t           awaited [$];
    int unsigned       n_errors;
    int unsigned       n_checked;
    int unsigned       status_hits [4];

    function new();
      total_mem = TOTAL_RESET;
      reserved = RESERVED_RESET;
      for (int i = 0; i < PARTS; i++) begin
        sizes[i] = '0;
        taken[i] = 1'b0;
      end
      count = 0;
      alloc_started = 1'b0;
      n_errors = 0;
      n_checked = 0;
      for (int i = 0; i < 4; i++) status_hits[i] = 0;
      recompute();
    endfunction

    function void recompute();
      int left;
      left = int'(total_mem) - int'(reserved);
      for (int i = 0; i < count; i++) left -= int'(sizes[i]);
      space_left = (left > 0) ? left[SIZE_W-1:0] : '0;
    endfunction

    function logic [ADDR_W-1:0] base_of(int unsigned pos);
      int a;
      a = int'(reserved);
      for (int i = 0; i < pos; i++) a += int'(sizes[i]);
      return a[ADDR_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_TOTAL) total_mem = val;
      else reserved = val;
      recompute();
    endfunction

    function void note_request(logic op, logic [SIZE_W-1:0] sz);
      answer_t     a;
      int unsigned pos;
      bit          found;
      a = '0;
      if (op == OP_ADD) begin
        if (alloc_started) begin
          a.status = ST_LATE;
        end else if (count >= PARTS || sz == 0 || sz > space_left) begin
          a.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < count && sizes[pos] <= sz) pos++;
          for (int i = count; i > pos; i--) begin
            sizes[i] = sizes[i-1];
            taken[i] = taken[i-1];
          end
          sizes[pos] = sz;
          taken[pos] = 1'b0;
          count++;
          space_left = space_left - sz;
          a.status = ST_OK;
          a.part_index = INDEX_W'(pos + 1);
          a.start_addr = base_of(pos);
          a.end_addr = a.start_addr + sz - 8'd1;
        end
      end else begin
        alloc_started = 1'b1;
        a.status = ST_NOFIT;
        found = 1'b0;
        for (int i = 0; i < count && !found; i++) begin
          if (!taken[i] && sizes[i] >= sz) begin
            taken[i] = 1'b1;
            found = 1'b1;
            a.status = ST_OK;
            a.part_index = INDEX_W'(i + 1);
            a.start_addr = base_of(i);
            a.end_addr = a.start_addr + sizes[i] - 8'd1;
            a.waste = sizes[i] - sz;
          end
        end
      end
      awaited.push_back(a);
    endfunction

    function void compare(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, got status %0d index %0d",
                 $time, got.status, got.part_index);
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      status_hits[want.status]++;
      compare("status", 32'(want.status), 32'(got.status));
      compare("part_index", 32'(want.part_index), 32'(got.part_index));
      compare("start_addr", 32'(want.start_addr), 32'(got.start_addr));
      compare("end_addr", 32'(want.end_addr), 32'(got.end_addr));
      compare("waste", 32'(want.waste), 32'(got.waste));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_op;
  logic [SIZE_W-1:0]   in_size;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [INDEX_W-1:0]  out_part_index;
  logic [ADDR_W-1:0]   out_start_addr;
  logic [ADDR_W-1:0]   out_end_addr;
  logic [SIZE_W-1:0]   out_waste;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  partition_book sb = new();
  int unsigned   cycles = 0;
  int unsigned   n_sent = 0;
  int unsigned   n_cfg = 0;
  bit            quiet = 1'b0;

  best_fit_partition_allocator_core #(.MAX_PARTS(PARTS)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_size        (in_size),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_part_index (out_part_index),
    .out_start_addr (out_start_addr),
    .out_end_addr   (out_end_addr),
    .out_waste      (out_waste),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_answer({out_status, out_part_index, out_start_addr, out_end_addr, out_waste});
  end

  task automatic send(logic op, logic [SIZE_W-1:0] sz);
    start <= 1'b1;
    in_op <= op;
    in_size <= sz;
    do @(posedge clk); while (busy);
    sb.note_request(op, sz);
    n_sent++;
  endtask

  task automatic hold_off(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    if ($urandom_range(0, 99) < 5) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_config();
    logic [CFG_IW-1:0] idx;
    logic [CFG_W-1:0]  val;
    bit                edge_case;
    idx = ($urandom_range(0, 1) == 0) ? REG_TOTAL : REG_RESERVED;
    edge_case = ($urandom_range(0, 99) < 20);
    if (idx == REG_TOTAL)
      val = edge_case ? (($urandom_range(0, 1) == 0) ? 8'd1 : 8'd255) :
                        CFG_W'($urandom_range(120, 255));
    else
      val = edge_case ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255) :
                        CFG_W'($urandom_range(0, 60));
    write_reg(idx, val);
  endtask

  function automatic logic [SIZE_W-1:0] part_size();
    if ($urandom_range(0, 99) < 80) return SIZE_W'($urandom_range(1, 8));
    return SIZE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [SIZE_W-1:0] job_size();
    int unsigned pick;
    int unsigned r;
    if (sb.count == 0 || $urandom_range(0, 99) < 40) return SIZE_W'($urandom_range(0, 255));
    pick = 32'(sb.sizes[$urandom_range(0, sb.count - 1)]);
    r = $urandom_range(0, 2);
    return (pick > r) ? SIZE_W'(pick - r) : SIZE_W'(pick);
  endfunction

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_ADD;
    in_size <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TOTAL;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // adds: zero and oversized refusals, sorted insert, equal sizes, register extremes
    send(OP_ADD, 8'd0);
    send(OP_ADD, 8'd255);
    send(OP_ADD, 8'd40);
    hold_off(2);
    send(OP_ADD, 8'd10);
    send(OP_ADD, 8'd40);
    write_reg(REG_TOTAL, 8'd255);
    write_reg(REG_RESERVED, 8'd0);
    send(OP_ADD, 8'd1);
    send(OP_ADD, 8'd255);
    write_reg(REG_RESERVED, 8'd255);
    send(OP_ADD, 8'd1);
    write_reg(REG_TOTAL, 8'd1);
    send(OP_ADD, 8'd1);
    write_reg(REG_TOTAL, 8'd200);
    write_reg(REG_RESERVED, 8'd20);

    for (int k = 0; k < 60; k++) begin
      if (k % 12 == 11) random_config();
      send(OP_ADD, part_size());
      hold_off(draw_gap());
    end

    // allocations: wrapped addresses, zero job, no fit, exact fit, equal sizes, late add
    write_reg(REG_RESERVED, 8'd240);
    send(OP_ALLOC, 8'd0);
    send(OP_ALLOC, 8'd255);
    send(OP_ALLOC, sb.sizes[sb.count-1]);
    hold_off(1);
    send(OP_ALLOC, 8'd40);
    send(OP_ALLOC, 8'd40);
    send(OP_ADD, 8'd5);
    send(OP_ALLOC, 8'd1);

    for (int k = 0; k < 420; k++) begin
      if (k % 35 == 34) random_config();
      if ($urandom_range(0, 99) < 15) send(OP_ADD, SIZE_W'($urandom_range(0, 255)));
      else send(OP_ALLOC, job_size());
      hold_off(draw_gap());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d register writes, %0d partitions",
             n_sent, sb.n_checked, n_cfg, sb.count);
    $display("outcomes: %0d ok, %0d no fit, %0d refused for room, %0d add after allocation",
             sb.status_hits[ST_OK], sb.status_hits[ST_NOFIT], sb.status_hits[ST_FULL],
             sb.status_hits[ST_LATE]);
    if (sb.n_errors == 0 && sb.awaited.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
